FILE: rtl/atbd_pkg.sv
// ----------------------------------------------------------------------------
// Adaptive threshold beat detector package
// Widths, register indexes, reset values and shared types of the detector.
// ----------------------------------------------------------------------------
package atbd_pkg;

    localparam int SAMPLE_W   = 12;
    localparam int FRAC_W     = 4;
    localparam int CNT_W      = 6;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;
    localparam int S_TDATA_W  = 16;
    localparam int M_TDATA_W  = 16;

    // span * fraction is at most 4095 * 10 and fits in 16 bits.
    localparam int PROD_W  = 16;
    localparam int PROD2_W = 2 * PROD_W;

    // floor(x / 10) == (x * 0xCCCD) >> 19 for every 16-bit x.
    localparam logic [PROD_W-1:0] RECIP10     = 16'hCCCD;
    localparam int                RECIP_SHIFT = 19;

    localparam logic [FRAC_W-1:0] FRAC_MAX = 4'd10;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRACTION   = 3'd0,
        CFG_WIN_FIRST  = 3'd1,
        CFG_WIN_LAST   = 3'd2,
        CFG_CYCLE_LAST = 3'd3,
        CFG_MIN_SEED   = 3'd4
    } t_cfg_idx;

    localparam logic [FRAC_W-1:0]   FRACTION_RST   = 4'd2;
    localparam logic [CNT_W-1:0]    WIN_FIRST_RST  = 6'd33;
    localparam logic [CNT_W-1:0]    WIN_LAST_RST   = 6'd41;
    localparam logic [CNT_W-1:0]    CYCLE_LAST_RST = 6'd43;
    localparam logic [SAMPLE_W-1:0] MIN_SEED_RST   = 12'd3000;

    typedef struct packed {
        logic [FRAC_W-1:0]   fraction_tenths;
        logic [CNT_W-1:0]    window_first;
        logic [CNT_W-1:0]    window_last;
        logic [CNT_W-1:0]    cycle_last;
        logic [SAMPLE_W-1:0] min_seed;
    } t_cfg;

    typedef struct packed {
        logic [SAMPLE_W-1:0] level_used;
        logic                above;
        logic                beat;
    } t_result;

endpackage

FILE: rtl/atbd_cfg.sv
// ----------------------------------------------------------------------------
// Configuration register file
// Holds the five detector settings, written through the configuration port.
// ----------------------------------------------------------------------------
module atbd_cfg (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [atbd_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [atbd_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output atbd_pkg::t_cfg                   o_cfg
);
    import atbd_pkg::*;

    t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.fraction_tenths <= FRACTION_RST;
            r_cfg.window_first    <= WIN_FIRST_RST;
            r_cfg.window_last     <= WIN_LAST_RST;
            r_cfg.cycle_last      <= CYCLE_LAST_RST;
            r_cfg.min_seed        <= MIN_SEED_RST;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_FRACTION:   r_cfg.fraction_tenths <= i_cfg_data[FRAC_W-1:0];
                CFG_WIN_FIRST:  r_cfg.window_first    <= i_cfg_data[CNT_W-1:0];
                CFG_WIN_LAST:   r_cfg.window_last     <= i_cfg_data[CNT_W-1:0];
                CFG_CYCLE_LAST: r_cfg.cycle_last      <= i_cfg_data[CNT_W-1:0];
                CFG_MIN_SEED:   r_cfg.min_seed        <= i_cfg_data[SAMPLE_W-1:0];
                default: begin
                end
            endcase
        end
    end

endmodule

FILE: rtl/atbd_track.sv
// ----------------------------------------------------------------------------
// Peak tracker
// Compares a sample with the threshold, then updates the running and window
// max/min pairs, the cycle counter and the pending threshold terms.
// ----------------------------------------------------------------------------
module atbd_track (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  atbd_pkg::t_cfg                 i_cfg,
    input  logic                           i_adv,
    input  logic [atbd_pkg::SAMPLE_W-1:0]  i_sample,
    output atbd_pkg::t_result              o_res
);
    import atbd_pkg::*;

    logic [SAMPLE_W-1:0] r_run_max, n_run_max;
    logic [SAMPLE_W-1:0] r_run_min, n_run_min;
    logic [SAMPLE_W-1:0] r_win_max, n_win_max;
    logic [SAMPLE_W-1:0] r_win_min, n_win_min;
    logic [CNT_W-1:0]    r_cnt, n_cnt;
    logic [SAMPLE_W-1:0] r_thr_max, n_thr_max;
    logic [PROD_W-1:0]   r_thr_prod, n_thr_prod;
    logic                r_was_above;

    logic [PROD2_W-1:0]  w_cut_full;
    logic [SAMPLE_W-1:0] w_level;
    logic                w_above;
    logic [SAMPLE_W-1:0] w_upd_max, w_upd_min;
    logic [SAMPLE_W-1:0] w_span;
    logic [FRAC_W-1:0]   w_frac;
    logic [CNT_W-1:0]    w_cnt_inc;
    logic                w_in_win;
    logic [SAMPLE_W-1:0] w_win_max, w_win_min;

    // The threshold is kept as max and span*fraction; the division by ten
    // is done here, ahead of the compare.
    assign w_cut_full = PROD2_W'(r_thr_prod) * PROD2_W'(RECIP10);
    assign w_level    = r_thr_max - w_cut_full[RECIP_SHIFT +: SAMPLE_W];
    assign w_above    = (i_sample > w_level);

    assign o_res.level_used = w_level;
    assign o_res.above      = w_above;
    assign o_res.beat       = w_above && !r_was_above;

    always_comb begin
        w_upd_max = (i_sample > r_run_max) ? i_sample : r_run_max;
        w_upd_min = (i_sample < r_run_min) ? i_sample : r_run_min;
        w_frac    = (i_cfg.fraction_tenths > FRAC_MAX) ? FRAC_MAX : i_cfg.fraction_tenths;
        w_span    = (w_upd_max >= w_upd_min) ? (w_upd_max - w_upd_min) : '0;

        n_thr_max  = w_upd_max;
        n_thr_prod = PROD_W'(w_span) * PROD_W'(w_frac);

        w_cnt_inc = r_cnt + CNT_W'(1);
        w_in_win  = (w_cnt_inc >= i_cfg.window_first) && (w_cnt_inc <= i_cfg.window_last);
        w_win_max = r_win_max;
        w_win_min = r_win_min;
        if (w_in_win) begin
            if (i_sample > r_win_max) w_win_max = i_sample;
            if (i_sample < r_win_min) w_win_min = i_sample;
        end

        // At the end of a cycle the window pair takes over and is reseeded.
        if (w_cnt_inc > i_cfg.cycle_last) begin
            n_cnt     = '0;
            n_run_max = w_win_max;
            n_run_min = w_win_min;
            n_win_max = '0;
            n_win_min = i_cfg.min_seed;
        end else begin
            n_cnt     = w_cnt_inc;
            n_run_max = w_upd_max;
            n_run_min = w_upd_min;
            n_win_max = w_win_max;
            n_win_min = w_win_min;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_max   <= '0;
            r_run_min   <= MIN_SEED_RST;
            r_win_max   <= '0;
            r_win_min   <= MIN_SEED_RST;
            r_cnt       <= '0;
            r_thr_max   <= '0;
            r_thr_prod  <= '0;
            r_was_above <= 1'b0;
        end else if (i_adv) begin
            r_run_max   <= n_run_max;
            r_run_min   <= n_run_min;
            r_win_max   <= n_win_max;
            r_win_min   <= n_win_min;
            r_cnt       <= n_cnt;
            r_thr_max   <= n_thr_max;
            r_thr_prod  <= n_thr_prod;
            r_was_above <= w_above;
        end
    end

endmodule

FILE: rtl/adaptive_threshold_beat_detector.sv
// ----------------------------------------------------------------------------
// Adaptive threshold beat detector
// Flags pulse beats on rising crossings of a threshold that tracks the
// signal's recent max/min span.
// ----------------------------------------------------------------------------
// Usage:
//   Samples enter on the s_axis channel, one per beat. Every sample gives
//   exactly one result on the m_axis channel: the beat flag, the above flag
//   and the threshold the sample was compared against.
//   Settings are written on the cfg channel (index, data), which is always
//   ready; write them only while no sample is in flight.
//   An accepted sample is held in the input register, then processed into
//   the output register once that is free or being read, where its result
//   is offered on m_axis.
//   Throughput: one sample per cycle while the receiver does not stall. The
//   input register and the output register form a two-entry pipeline; the
//   tracking update for a sample is done between the two registers.
//   When the receiver stalls, the result waits in the output register, one
//   more sample is held in the input register, and s_axis_tready then drops.
//   Reset empties both pipeline registers, loads the default settings and
//   puts the trackers at max 0, min 3000, threshold 0.
// ----------------------------------------------------------------------------
module adaptive_threshold_beat_detector (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [atbd_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [atbd_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [atbd_pkg::S_TDATA_W-1:0]   s_axis_tdata,  // [11:0] sample, [15:12] zero
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [atbd_pkg::M_TDATA_W-1:0]   m_axis_tdata   // [0] beat, [1] above,
                                                            // [13:2] level_used, [15:14] zero
);
    import atbd_pkg::*;

    t_cfg                w_cfg;
    t_result             w_res;
    logic                w_adv;
    logic                r_in_valid;
    logic [SAMPLE_W-1:0] r_in_sample;
    logic                r_out_valid;
    t_result             r_out;

    atbd_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    atbd_track u_track (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (w_cfg),
        .i_adv    (w_adv),
        .i_sample (r_in_sample),
        .o_res    (w_res)
    );

    assign w_adv         = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_adv;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = M_TDATA_W'(r_out);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tvalid && s_axis_tready) begin
            r_in_valid <= 1'b1;
        end else if (w_adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_sample <= s_axis_tdata[SAMPLE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out <= w_res;
        end
    end

    // A beat is always a sample above the threshold.
    a_beat_above: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[0] |-> m_axis_tdata[1])
        else $error("beat flagged without above");

    // A sample waiting in the input register is neither lost nor altered.
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !w_adv |=> r_in_valid && $stable(r_in_sample))
        else $error("waiting sample lost or changed");

    // A processed sample always lands in the output register.
    a_adv_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv |=> r_out_valid)
        else $error("processed sample produced no result");

    // Reset empties the pipeline.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid && s_axis_tready)
        else $error("pipeline not empty after reset");

endmodule

FILE: tb/atbd_checker.sv
// ----------------------------------------------------------------------------
// Adaptive threshold beat detector checker
// Watches the settings, sample and result channels of the detector. It keeps
// its own copy of the tracker state, predicts the flags and the threshold for
// every accepted sample, and compares each result beat with the oldest
// prediction.
// ----------------------------------------------------------------------------
module atbd_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_valid,
    input  logic                            i_cfg_ready,
    input  logic [atbd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [atbd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                            i_smp_valid,
    input  logic                            i_smp_ready,
    input  logic [atbd_pkg::S_TDATA_W-1:0]  i_smp_data,
    input  logic                            i_res_valid,
    input  logic                            i_res_ready,
    input  logic [atbd_pkg::M_TDATA_W-1:0]  i_res_data,
    output int                              o_mismatches,
    output int                              o_outstanding,
    output int                              o_checked,
    output int                              o_beats
);
    import atbd_pkg::*;

    t_cfg                settings;
    logic [SAMPLE_W-1:0] run_max;
    logic [SAMPLE_W-1:0] run_min;
    logic [SAMPLE_W-1:0] win_max;
    logic [SAMPLE_W-1:0] win_min;
    logic [SAMPLE_W-1:0] level;
    logic [CNT_W-1:0]    cycle_pos;
    logic                was_above;

    t_result crossing_q[$];
    t_result want;
    t_result got;

    // Advances the tracker by one sample and returns what the detector
    // should report for it.
    function automatic t_result predict_crossing(input logic [SAMPLE_W-1:0] smp);
        t_result     r;
        int unsigned frac;
        int unsigned span;
        int unsigned cut;
        r.level_used = level;
        r.above      = (smp > level);
        r.beat       = r.above && !was_above;
        was_above    = r.above;

        if (smp > run_max) run_max = smp;
        if (smp < run_min) run_min = smp;

        frac  = (settings.fraction_tenths > FRAC_MAX) ? 32'(FRAC_MAX)
                                                      : 32'(settings.fraction_tenths);
        span  = (run_max >= run_min) ? 32'(run_max - run_min) : 32'(0);
        cut   = span * frac / 10;
        level = SAMPLE_W'(32'(run_max) - cut);

        cycle_pos = cycle_pos + CNT_W'(1);
        if (cycle_pos >= settings.window_first && cycle_pos <= settings.window_last) begin
            if (smp > win_max) win_max = smp;
            if (smp < win_min) win_min = smp;
        end

        // The restart only touches state used by later samples.
        if (cycle_pos > settings.cycle_last) begin
            cycle_pos = '0;
            run_max   = win_max;
            run_min   = win_min;
            win_max   = '0;
            win_min   = settings.min_seed;
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            settings.fraction_tenths = FRACTION_RST;
            settings.window_first    = WIN_FIRST_RST;
            settings.window_last     = WIN_LAST_RST;
            settings.cycle_last      = CYCLE_LAST_RST;
            settings.min_seed        = MIN_SEED_RST;
            run_max      = '0;
            run_min      = MIN_SEED_RST;
            win_max      = '0;
            win_min      = MIN_SEED_RST;
            level        = '0;
            cycle_pos    = '0;
            was_above    = 1'b0;
            crossing_q.delete();
            o_mismatches = 0;
            o_checked    = 0;
            o_beats      = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_FRACTION:   settings.fraction_tenths = i_cfg_data[FRAC_W-1:0];
                    CFG_WIN_FIRST:  settings.window_first    = i_cfg_data[CNT_W-1:0];
                    CFG_WIN_LAST:   settings.window_last     = i_cfg_data[CNT_W-1:0];
                    CFG_CYCLE_LAST: settings.cycle_last      = i_cfg_data[CNT_W-1:0];
                    CFG_MIN_SEED:   settings.min_seed        = i_cfg_data[SAMPLE_W-1:0];
                    default: ;
                endcase
            end

            // Results are matched before this edge's sample is queued, so a
            // stray result can never pair with a sample just taken in.
            if (i_res_valid && i_res_ready) begin
                got = i_res_data[$bits(t_result)-1:0];
                if (crossing_q.size() == 0) begin
                    $error("result beat with no sample waiting: data 0x%h", i_res_data);
                    o_mismatches++;
                end else begin
                    want = crossing_q.pop_front();
                    o_checked++;
                    if (got.beat) o_beats++;
                    if (got.beat !== want.beat) begin
                        $error("beat: expected %0d, got %0d", want.beat, got.beat);
                        o_mismatches++;
                    end
                    if (got.above !== want.above) begin
                        $error("above: expected %0d, got %0d", want.above, got.above);
                        o_mismatches++;
                    end
                    if (got.level_used !== want.level_used) begin
                        $error("level_used: expected %0d, got %0d",
                               want.level_used, got.level_used);
                        o_mismatches++;
                    end
                    if (i_res_data[M_TDATA_W-1:$bits(t_result)] !== '0) begin
                        $error("tdata pad: expected 0, got %0d",
                               i_res_data[M_TDATA_W-1:$bits(t_result)]);
                        o_mismatches++;
                    end
                end
            end

            if (i_smp_valid && i_smp_ready)
                crossing_q.push_back(predict_crossing(i_smp_data[SAMPLE_W-1:0]));
        end
        o_outstanding = crossing_q.size();
    end

endmodule

FILE: tb/tb_top.sv
// ----------------------------------------------------------------------------
// Adaptive threshold beat detector testbench
// Drives pulse-like waveforms, random and extreme samples through the detector
// under a series of settings, with random sender gaps and receiver stalls.
// A separate checker predicts every result and counts mismatches.
// ----------------------------------------------------------------------------
module tb_top;
    import atbd_pkg::*;

    localparam int SMP_MAX     = (1 << SAMPLE_W) - 1;
    localparam logic [SAMPLE_W-1:0] SMP_TOP = SAMPLE_W'(SMP_MAX);
    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASE_ITEMS = 90;
    localparam int RANDOM_PHASES = 8;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [S_TDATA_W-1:0]  s_axis_tdata;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [M_TDATA_W-1:0]  m_axis_tdata;

    int mismatches;
    int outstanding;
    int checked;
    int beats;

    int samples_sent;
    int settings_used;
    int burst_left;
    int tx_idle_pct;
    int rx_stall_pct;
    int stall_left;

    adaptive_threshold_beat_detector uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    atbd_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_smp_valid   (s_axis_tvalid),
        .i_smp_ready   (s_axis_tready),
        .i_smp_data    (s_axis_tdata),
        .i_res_valid   (m_axis_tvalid),
        .i_res_ready   (m_axis_tready),
        .i_res_data    (m_axis_tdata),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding),
        .o_checked     (checked),
        .o_beats       (beats)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $error("run did not finish within %0d cycles", CYCLE_LIMIT);
        $display("FAILED: results differ");
        $finish;
    end

    // Receiver: ready most of the time, with stalls of random length whose
    // rate is set per phase.
    initial begin
        m_axis_tready = 1'b0;
        stall_left    = 0;
        forever begin
            @(negedge i_clk);
            if (stall_left > 0) begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end else if (rx_stall_pct != 0 && $urandom_range(1, 100) <= rx_stall_pct) begin
                m_axis_tready <= 1'b0;
                stall_left = $urandom_range(0, 5);
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Called right after a falling edge; returns right after one.
    task automatic send_sample(input logic [SAMPLE_W-1:0] value);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 30);
            gap = ($urandom_range(1, 100) <= tx_idle_pct) ? $urandom_range(1, 5) : 0;
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(S_TDATA_W - SAMPLE_W){1'b0}}, value};
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
        samples_sent++;
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        do @(negedge i_clk); while (outstanding != 0);
        repeat (2) @(negedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic load_setting(input logic [FRAC_W-1:0] frac, input logic [CNT_W-1:0] first,
                                input logic [CNT_W-1:0] last, input logic [CNT_W-1:0] cyc_last,
                                input logic [SAMPLE_W-1:0] seed);
        write_reg(CFG_FRACTION, CFG_DATA_W'(frac));
        write_reg(CFG_WIN_FIRST, CFG_DATA_W'(first));
        write_reg(CFG_WIN_LAST, CFG_DATA_W'(last));
        write_reg(CFG_CYCLE_LAST, CFG_DATA_W'(cyc_last));
        write_reg(CFG_MIN_SEED, seed);
        settings_used++;
    endtask

    // One point of a pulse-shaped wave: fast rise over the first quarter of
    // the period, slow decay over the rest, plus some noise.
    function automatic logic [SAMPLE_W-1:0] pulse_point(input int k, input int base,
                                                        input int amp, input int period,
                                                        input int noise);
        int pos;
        int rise;
        int shape;
        int jitter;
        int v;
        pos  = k % period;
        rise = period / 4 + 1;
        if (pos < rise) shape = pos * 1000 / rise;
        else shape = (period - pos) * 1000 / (period - rise);
        jitter = int'($urandom_range(0, 2 * noise)) - noise;
        v = base + amp * shape / 1000 + jitter;
        if (v < 0) v = 0;
        if (v > SMP_MAX) v = SMP_MAX;
        return v[SAMPLE_W-1:0];
    endfunction

    task automatic send_pulse_train(input int count);
        int base;
        int amp;
        int period;
        int noise;
        base   = $urandom_range(0, 3500);
        amp    = $urandom_range(20, SMP_MAX - base);
        period = $urandom_range(4, 40);
        noise  = $urandom_range(0, 60);
        for (int k = 0; k < count; k++)
            send_sample(pulse_point(k, base, amp, period, noise));
    endtask

    task automatic run_random_phase(input int items);
        int done;
        int pick;
        int len;
        done = 0;
        while (done < items) begin
            pick = $urandom_range(0, 9);
            if (pick <= 6) begin
                len = $urandom_range(10, 40);
                if (len > items - done) len = items - done;
                send_pulse_train(len);
            end else if (pick <= 8) begin
                len = $urandom_range(1, 10);
                if (len > items - done) len = items - done;
                repeat (len) send_sample(SAMPLE_W'($urandom_range(0, SMP_MAX)));
            end else begin
                len = 1;
                send_sample($urandom_range(0, 1) ? SMP_TOP : '0);
            end
            done += len;
        end
    endtask

    initial begin
        logic [CNT_W-1:0] first;
        logic [CNT_W-1:0] last;
        logic [CNT_W-1:0] cyc_last;
        logic [SAMPLE_W-1:0] seed;

        i_rst_n       = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = CFG_FRACTION;
        i_cfg_data    = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        samples_sent  = 0;
        settings_used = 0;
        burst_left    = 0;
        tx_idle_pct   = 0;
        rx_stall_pct  = 0;

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset settings: rail-to-rail samples and rising crossings.
        send_sample(0);
        send_sample(SMP_TOP);
        send_sample(SMP_TOP);
        send_sample(0);
        send_sample(2048);
        send_sample(SMP_TOP);
        send_sample(1);
        send_sample(SMP_TOP - SAMPLE_W'(1));
        wait_idle();

        // Fraction above ten with a short cycle, so restarts come quickly.
        load_setting(4'd15, 6'd1, 6'd2, 6'd3, SMP_TOP);
        send_sample(100);
        send_sample(3000);
        send_sample(50);
        send_sample(4000);
        send_sample(200);
        send_sample(2500);
        wait_idle();

        // Empty window: after the first restart, every restart adopts max zero and the seed as min.
        load_setting(4'd0, 6'd5, 6'd2, 6'd1, 12'd0);
        send_sample(1000);
        send_sample(3000);
        send_sample(500);
        send_sample(4000);
        send_sample(0);
        wait_idle();

        // Restart that can never fire; the counter wraps instead.
        load_setting(4'd10, 6'd0, 6'd63, 6'd63, SMP_TOP);
        send_sample(700);
        send_sample(2900);
        send_sample(10);
        send_sample(3900);
        send_sample(1500);
        wait_idle();

        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            case (phase)
                0: load_setting(4'd15, 6'd63, 6'd63, 6'd63, SMP_TOP);
                1: load_setting(4'd0, 6'd0, 6'd0, 6'd0, 12'd0);
                2: load_setting(4'd10, 6'd1, 6'd62, 6'd62, SMP_TOP);
                default: begin
                    cyc_last = $urandom_range(0, 1) ? CNT_W'($urandom_range(0, 20))
                                                    : CNT_W'($urandom_range(0, 63));
                    first = CNT_W'($urandom_range(0, 63));
                    if ($urandom_range(0, 4) == 0) first = CNT_W'($urandom_range(0, 63));
                    else first = CNT_W'($urandom_range(0, cyc_last + 1));
                    last = ($urandom_range(0, 5) == 0) ? CNT_W'($urandom_range(0, 63))
                                                       : CNT_W'($urandom_range(first, 63));
                    case ($urandom_range(0, 3))
                        0:       seed = '0;
                        1:       seed = SMP_TOP;
                        default: seed = SAMPLE_W'($urandom_range(0, SMP_MAX));
                    endcase
                    load_setting(FRAC_W'($urandom_range(0, 15)), first, last, cyc_last,
                                 seed);
                end
            endcase
            // Some phases run without any idling on either side.
            tx_idle_pct  = (phase % 3 == 1) ? 0 : $urandom_range(10, 60);
            rx_stall_pct = (phase % 3 == 1) ? 0 : $urandom_range(10, 50);
            run_random_phase(PHASE_ITEMS);
            wait_idle();
        end

        repeat (8) @(negedge i_clk);

        $display("Sent %0d samples under %0d settings besides reset; %0d results checked.",
                 samples_sent, settings_used, checked);
        $display("Detector flagged %0d beats across pulse trains, noise and rail values.",
                 beats);
        if (mismatches == 0 && outstanding == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

FILE: filelist.f
rtl/atbd_pkg.sv
rtl/atbd_cfg.sv
rtl/atbd_track.sv
rtl/adaptive_threshold_beat_detector.sv
tb/atbd_checker.sv
tb/tb_top.sv
